/* design/round_robin_task_slot_scheduler_unit_macros.svh */
// Assertion helpers shared by the checker.
// Both forms expect clk and rst_n in scope; checks are off while reset is low.
`ifndef ROUND_ROBIN_TASK_SLOT_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_TASK_SLOT_SCHEDULER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRTSS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Consequent must hold in the cycle after the antecedent.
`define RRTSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

/* design/rrtss_pkg.sv */
package rrtss_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int CFG_W         = 4;
  localparam int REQ_W         = 2;
  localparam int TIME_W        = 32;
  localparam int DLY_W         = 16;
  localparam int LEN_W         = 15;
  localparam int SP_W          = 16;
  localparam int STATUS_W      = 2;
  localparam int SLOT_OUT_W    = 3;

  localparam logic [CFG_W-1:0] MAX_TASKS_RST = 4'd8;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_END   = 2'd1,
    REQ_DELAY = 2'd2,
    REQ_SCHED = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FREE  = 2'd1,
    STAT_NO_READY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic dispatch;
    logic scan;
    logic commit_echo;
    logic commit_scan;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic cancel;
    logic hit;
    logic exhausted;
    logic out_free;
  } dp_stat_t;

endpackage

/* design/rrtss_dp.sv */
module rrtss_dp
  import rrtss_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic [TIME_W-1:0]       in_now_ms,
  input  logic signed [DLY_W-1:0] in_delay_ms,
  input  logic [SP_W-1:0]         in_stack_ptr,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [STATUS_W-1:0]     out_status,
  output logic [SLOT_OUT_W-1:0]   out_slot,
  output logic [SP_W-1:0]         out_stack_ptr_out
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CMP_W  = ((SLOT_W > CFG_W) ? SLOT_W : CFG_W) + 1;

  // config and control state
  logic [CFG_W-1:0]     max_tasks_r;
  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic [NUM_SLOTS-1:0] active_r, active_nxt;
  logic [SLOT_W-1:0]    cur_r, cur_nxt;
  logic                 out_valid_r;
  logic                 eval_valid_r;

  // captured transaction
  req_t                    req_r;
  logic [TIME_W-1:0]       now_r;
  logic signed [DLY_W-1:0] dly_r;
  logic [SP_W-1:0]         sp_r;

  // scan pipeline
  logic [SLOT_W-1:0] ai_r;
  logic [CMP_W-1:0]  issue_cnt_r;
  logic [SLOT_W-1:0] eval_idx_r;
  logic              eval_last_r;

  // slot memories
  logic [TIME_W-1:0] start_mem [NUM_SLOTS];
  logic [LEN_W-1:0]  len_mem   [NUM_SLOTS];
  logic [SP_W-1:0]   sp_mem    [NUM_SLOTS];
  logic [TIME_W-1:0] rd_start_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic [SP_W-1:0]   rd_sp_r;

  // pending result and output register
  status_t           res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [SP_W-1:0]   res_sp_r;
  status_t           out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [SP_W-1:0]   out_sp_r;

  logic [CMP_W-1:0]  cnt;
  logic [CMP_W-1:0]  ai_plus, cur_plus;
  logic [SLOT_W-1:0] ai_wrap, scan_start;
  logic              issue_more, issue;
  logic              cancel, is_add;
  logic              used_at, act_at, expired, hit;
  logic [TIME_W-1:0] elapsed;
  logic              dly_we, sp_we;
  logic [SLOT_W-1:0] sp_waddr;

  // effective slot count: 0 acts as 1, clamp at NUM_SLOTS
  always_comb begin
    if (max_tasks_r == '0) begin
      cnt = CMP_W'(1);
    end else if (CMP_W'(max_tasks_r) > CMP_W'(NUM_SLOTS)) begin
      cnt = CMP_W'(NUM_SLOTS);
    end else begin
      cnt = CMP_W'(max_tasks_r);
    end
  end

  assign ai_plus    = CMP_W'(ai_r) + CMP_W'(1);
  assign ai_wrap    = (ai_plus >= cnt) ? '0 : ai_plus[SLOT_W-1:0];
  assign cur_plus   = CMP_W'(cur_r) + CMP_W'(1);
  assign is_add     = (req_r == REQ_ADD);
  assign scan_start = (is_add || cur_plus >= cnt) ? '0 : cur_plus[SLOT_W-1:0];
  assign issue_more = (issue_cnt_r < cnt);
  assign issue      = cmd.scan && issue_more;
  assign cancel     = (dly_r <= 0);

  // readiness of the slot in the evaluate stage
  assign used_at = used_r[eval_idx_r];
  assign act_at  = active_r[eval_idx_r];
  assign elapsed = now_r - rd_start_r;
  assign expired = (elapsed > TIME_W'(rd_len_r));
  assign hit     = eval_valid_r &&
                   (is_add ? !used_at : (used_at && (!act_at || expired)));

  assign stat.req       = req_r;
  assign stat.cancel    = cancel;
  assign stat.hit       = hit;
  assign stat.exhausted = eval_valid_r && eval_last_r && !hit;
  assign stat.out_free  = !out_valid_r || out_ready;

  // memory write controls
  assign dly_we   = cmd.dispatch && (req_r == REQ_DELAY) && !cancel;
  assign sp_we    = (cmd.dispatch && !is_add && !((req_r == REQ_DELAY) && cancel)) ||
                    (cmd.commit_scan && hit && is_add);
  assign sp_waddr = cmd.dispatch ? cur_r : eval_idx_r;

  always_comb begin
    used_nxt   = used_r;
    active_nxt = active_r;
    cur_nxt    = cur_r;
    if (cmd.dispatch) begin
      if (req_r == REQ_END) begin
        used_nxt[cur_r] = 1'b0;
      end
      if (req_r == REQ_DELAY) begin
        active_nxt[cur_r] = !cancel;
      end
    end
    if (cmd.commit_scan && hit) begin
      active_nxt[eval_idx_r] = 1'b0;
      if (is_add) begin
        used_nxt[eval_idx_r] = 1'b1;
      end else begin
        cur_nxt = eval_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tasks_r  <= MAX_TASKS_RST;
      used_r       <= '0;
      active_r     <= '0;
      cur_r        <= '0;
      out_valid_r  <= 1'b0;
      eval_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_tasks_r <= cfg_wr_data;
      end
      used_r       <= used_nxt;
      active_r     <= active_nxt;
      cur_r        <= cur_nxt;
      eval_valid_r <= issue;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= req_t'(in_req_type);
      now_r <= in_now_ms;
      dly_r <= in_delay_ms;
      sp_r  <= in_stack_ptr;
    end
    if (cmd.dispatch) begin
      ai_r        <= scan_start;
      issue_cnt_r <= '0;
    end else if (issue) begin
      ai_r        <= ai_wrap;
      issue_cnt_r <= issue_cnt_r + CMP_W'(1);
      eval_idx_r  <= ai_r;
      eval_last_r <= (issue_cnt_r == cnt - CMP_W'(1));
    end
    if (cmd.commit_echo) begin
      res_status_r <= STAT_OK;
      res_slot_r   <= cur_r;
      res_sp_r     <= sp_r;
    end else if (cmd.commit_scan) begin
      if (hit) begin
        res_status_r <= STAT_OK;
        res_slot_r   <= eval_idx_r;
        res_sp_r     <= is_add ? sp_r : rd_sp_r;
      end else begin
        res_status_r <= is_add ? STAT_NO_FREE : STAT_NO_READY;
        res_slot_r   <= cur_r;
        res_sp_r     <= sp_r;
      end
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_sp_r     <= res_sp_r;
    end
  end

  // slot memories: one write port each, registered read at the scan address
  always_ff @(posedge clk) begin
    if (dly_we) begin
      start_mem[cur_r] <= now_r;
      len_mem[cur_r]   <= dly_r[LEN_W-1:0];
    end
    if (sp_we) begin
      sp_mem[sp_waddr] <= sp_r;
    end
    rd_start_r <= start_mem[ai_r];
    rd_len_r   <= len_mem[ai_r];
    rd_sp_r    <= sp_mem[ai_r];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = SLOT_OUT_W'(out_slot_r);
  assign out_stack_ptr_out = out_sp_r;

endmodule

/* design/rrtss_ctrl.sv */
module rrtss_ctrl
  import rrtss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.req == REQ_DELAY && stat.cancel) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit || stat.exhausted) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DISPATCH: begin
        cmd.dispatch    = 1'b1;
        cmd.commit_echo = (stat.req == REQ_DELAY) && stat.cancel;
      end
      S_SCAN: begin
        cmd.scan        = 1'b1;
        cmd.commit_scan = stat.hit || stat.exhausted;
      end
      S_RESULT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/round_robin_task_slot_scheduler_unit.sv */
// Round-robin task-slot scheduler. Each transaction is one request (add task,
// end current task, delay current task, schedule) and yields exactly one
// result: status, slot and the stack pointer to resume. Requests are handled
// one at a time: accept, a dispatch state, then a scan that visits one slot
// per cycle through the slot memories (registered read, so the last slot is
// judged in the cycle after it is addressed), then a result state that hands
// the result to the output register once it is free. A schedule, end or
// positive delay scans up to count slots (count = max_tasks clamped to
// 1..NUM_SLOTS), stopping early when a ready slot is found; an add scans
// from slot 0 and stops at the first free slot; a zero or negative delay
// finishes after dispatch. The output register lets the next transaction
// be accepted while a result is still waiting. max_tasks is written through
// cfg_wr_en/cfg_wr_data and must only change while the block is idle. Slot
// stack pointers and delay times live in memories with no reset; they are
// only read after being written.
module round_robin_task_slot_scheduler_unit
  import rrtss_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic [TIME_W-1:0]       in_now_ms,
  input  logic signed [DLY_W-1:0] in_delay_ms,
  input  logic [SP_W-1:0]         in_stack_ptr,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     out_status,
  output logic [SLOT_OUT_W-1:0]   out_slot,
  output logic [SP_W-1:0]         out_stack_ptr_out,
  // config: max_tasks
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing: idle -> dispatch -> scan -> result (a cancelled delay skips the scan)
  rrtss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot flags, slot memories, scan pipeline and output register
  rrtss_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_req_type       (in_req_type),
    .in_now_ms         (in_now_ms),
    .in_delay_ms       (in_delay_ms),
    .in_stack_ptr      (in_stack_ptr),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_stack_ptr_out (out_stack_ptr_out)
  );

endmodule

/* design/rrtss_checker.sv */
`include "round_robin_task_slot_scheduler_unit_macros.svh"

module rrtss_checker
  import rrtss_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [STATUS_W-1:0]   out_status,
  input logic [SLOT_OUT_W-1:0] out_slot,
  input logic [SP_W-1:0]       out_stack_ptr_out
);

  logic [STATUS_W+SLOT_OUT_W+SP_W-1:0] out_payload;
  logic                                status_known;

  assign out_payload  = {out_status, out_slot, out_stack_ptr_out};
  assign status_known = (out_status == STAT_OK) || (out_status == STAT_NO_FREE) ||
                        (out_status == STAT_NO_READY);

  // a stalled result holds
  `RRTSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // only defined status codes leave the block
  `RRTSS_ASSERT_SAME(a_status_code, out_valid, status_known)

  // one transaction at a time: busy right after accept
  `RRTSS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a fresh result only appears after a busy cycle
  `RRTSS_ASSERT_SAME(a_result_after_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind round_robin_task_slot_scheduler_unit rrtss_checker u_rrtss_checker (.*);

/* sim/round_robin_task_slot_scheduler_unit_test.sv */
`timescale 1ns / 1ps

module round_robin_task_slot_scheduler_unit_test;
  import rrtss_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_ITEMS   = 144;
  // Longest request scans every slot; leave a margin on top of that.
  localparam int SETTLE_CYCLES = NUM_SLOTS_DEF + 8;
  // max_tasks per random phase: extremes (0, 1, NUM_SLOTS, all ones) plus a few
  // in-between counts.
  localparam logic [CFG_W-1:0] CFG_PLAN [8] = '{4'd1, 4'd15, 4'd0, 4'd8,
                                                4'd3, 4'd7, 4'd2, 4'd5};

  typedef struct packed {
    status_t               status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [SP_W-1:0]       sp;
  } sched_result_t;

  // Shadow copy of the slot table. Each accepted request is applied here at
  // acceptance; the outcome is queued and compared against the DUT output.
  class sched_scoreboard;
    logic [CFG_W-1:0]  max_tasks;
    bit                slot_used  [NUM_SLOTS_DEF];
    bit                wait_on    [NUM_SLOTS_DEF];
    logic [TIME_W-1:0] wait_start [NUM_SLOTS_DEF];
    logic [LEN_W-1:0]  wait_len   [NUM_SLOTS_DEF];
    logic [SP_W-1:0]   saved_sp   [NUM_SLOTS_DEF];
    int unsigned       cur_slot;
    sched_result_t     pending_q[$];
    int unsigned       errors;

    function new();
      max_tasks = MAX_TASKS_RST;
      cur_slot  = 0;
      errors    = 0;
      foreach (slot_used[i]) begin
        slot_used[i]  = 1'b0;
        wait_on[i]    = 1'b0;
        wait_start[i] = '0;
        wait_len[i]   = '0;
        saved_sp[i]   = '0;
      end
    endfunction

    // max_tasks clamped to 1..NUM_SLOTS
    function int unsigned slot_count();
      if (max_tasks == 0) return 1;
      if (max_tasks > NUM_SLOTS_DEF) return NUM_SLOTS_DEF;
      return max_tasks;
    endfunction

    function int unsigned tasks_alive();
      int unsigned cnt;
      cnt = 0;
      foreach (slot_used[i]) if (slot_used[i]) cnt++;
      return cnt;
    endfunction

    // Save outgoing sp, then round robin from the slot after current; the
    // current slot is visited last. Expired delays are cleared on the way.
    function status_t pick_next(logic [TIME_W-1:0] now, logic [SP_W-1:0] sp_in,
                                output logic [SP_W-1:0] sp_out);
      int unsigned       n;
      int unsigned       idx;
      logic [TIME_W-1:0] elapsed;
      n = slot_count();
      saved_sp[cur_slot] = sp_in;
      sp_out = sp_in;
      idx = (cur_slot + 1 >= n) ? 0 : cur_slot + 1;
      for (int unsigned k = 0; k < n; k++) begin
        if (slot_used[idx]) begin
          elapsed = now - wait_start[idx];
          if (wait_on[idx] && elapsed > TIME_W'(wait_len[idx])) wait_on[idx] = 1'b0;
          if (!wait_on[idx]) begin
            cur_slot = idx;
            sp_out   = saved_sp[idx];
            return STAT_OK;
          end
        end
        idx = (idx + 1 >= n) ? 0 : idx + 1;
      end
      return STAT_NO_READY;
    endfunction

    function void note_request(req_t rq, logic [TIME_W-1:0] now,
                               logic signed [DLY_W-1:0] dly, logic [SP_W-1:0] sp);
      sched_result_t r;
      int unsigned   n;
      r.status = STAT_OK;
      r.slot   = SLOT_OUT_W'(cur_slot);
      r.sp     = sp;
      case (rq)
        REQ_ADD: begin
          r.status = STAT_NO_FREE;
          n = slot_count();
          for (int unsigned i = 0; i < n; i++) begin
            if (!slot_used[i]) begin
              slot_used[i] = 1'b1;
              wait_on[i]   = 1'b0;
              saved_sp[i]  = sp;
              r.status     = STAT_OK;
              r.slot       = SLOT_OUT_W'(i);
              break;
            end
          end
        end
        REQ_END: begin
          slot_used[cur_slot] = 1'b0;
          r.status = pick_next(now, sp, r.sp);
          r.slot   = SLOT_OUT_W'(cur_slot);
        end
        REQ_DELAY: begin
          if (dly[DLY_W-1] || dly == '0) begin
            wait_on[cur_slot] = 1'b0;
          end else begin
            wait_start[cur_slot] = now;
            wait_len[cur_slot]   = dly[LEN_W-1:0];
            wait_on[cur_slot]    = 1'b1;
            r.status = pick_next(now, sp, r.sp);
            r.slot   = SLOT_OUT_W'(cur_slot);
          end
        end
        default: begin
          r.status = pick_next(now, sp, r.sp);
          r.slot   = SLOT_OUT_W'(cur_slot);
        end
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [SLOT_OUT_W-1:0] slot,
                               logic [SP_W-1:0] sp);
      sched_result_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result: status %0d slot %0d stack_ptr_out %h", st, slot, sp);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        errors++;
      end
      if (slot !== want.slot) begin
        $error("slot: expected %0d, actual %0d", want.slot, slot);
        errors++;
      end
      if (sp !== want.sp) begin
        $error("stack_ptr_out: expected %h, actual %h", want.sp, sp);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [REQ_W-1:0]        in_req_type;
  logic [TIME_W-1:0]       in_now_ms;
  logic signed [DLY_W-1:0] in_delay_ms;
  logic [SP_W-1:0]         in_stack_ptr;
  logic                    out_valid;
  logic                    out_ready;
  logic [STATUS_W-1:0]     out_status;
  logic [SLOT_OUT_W-1:0]   out_slot;
  logic [SP_W-1:0]         out_stack_ptr_out;
  logic                    cfg_wr_en;
  logic [CFG_W-1:0]        cfg_wr_data;

  sched_scoreboard sb = new();

  // percent chance, per cycle, that the sender holds off / the receiver stalls
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned cycle_count    = 0;

  round_robin_task_slot_scheduler_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_now_ms         (in_now_ms),
    .in_delay_ms       (in_delay_ms),
    .in_stack_ptr      (in_stack_ptr),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_stack_ptr_out (out_stack_ptr_out),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the DUT hangs on either handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("round_robin_task_slot_scheduler_unit_test failed");
      $finish;
    end
  end

  // Result side: ready toggles at the falling edge, transactions are taken at
  // the rising edge with pre-edge values.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_slot, out_stack_ptr_out);
  end

  // One request transaction. Valid is only dropped during an idle gap, so a
  // back-to-back request never sees valid lowered and raised in one step.
  task automatic send_req(req_t rq, logic [TIME_W-1:0] now,
                          logic signed [DLY_W-1:0] dly, logic [SP_W-1:0] sp);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= rq;
    in_now_ms    <= now;
    in_delay_ms  <= dly;
    in_stack_ptr <= sp;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rq, now, dly, sp);
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  // max_tasks only changes with the block idle.
  task automatic write_max_tasks(logic [CFG_W-1:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.max_tasks = val;
  endtask

  initial begin
    logic [TIME_W-1:0]       clock_ms;
    int unsigned             pick;
    int unsigned             add_lim;
    req_t                    rq;
    logic signed [DLY_W-1:0] dly;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = REQ_ADD;
    in_now_ms    = '0;
    in_delay_ms  = '0;
    in_stack_ptr = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed: reset config (8 slots) ----
    // empty table: schedule finds nothing ready
    send_req(REQ_SCHED, 32'h0, DLY_W'($urandom()), 16'h0000);
    // zero and most negative delay just cancel, no switch
    send_req(REQ_DELAY, 32'h0, 16'sd0, 16'hFFFF);
    send_req(REQ_DELAY, 32'h10, 16'sh8000, SP_W'($urandom()));
    // positive delay on an empty slot, then end with nothing to run
    send_req(REQ_DELAY, 32'h10, 16'sd5, SP_W'($urandom()));
    send_req(REQ_END, 32'h20, DLY_W'($urandom()), SP_W'($urandom()));
    // fill all slots, then one add too many
    for (int i = 0; i < NUM_SLOTS_DEF; i++)
      send_req(REQ_ADD, 32'h20, DLY_W'($urandom()),
               (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : SP_W'($urandom()));
    send_req(REQ_ADD, 32'h20, DLY_W'($urandom()), SP_W'($urandom()));
    send_req(REQ_SCHED, 32'd100, DLY_W'($urandom()), SP_W'($urandom()));
    // longest delay, shortest delay, then end of a running task
    send_req(REQ_DELAY, 32'd100, 16'sd32767, SP_W'($urandom()));
    send_req(REQ_DELAY, 32'd100, 16'sd1, SP_W'($urandom()));
    send_req(REQ_END, 32'd101, DLY_W'($urandom()), SP_W'($urandom()));
    // time at its top value: elapsed wraps around
    send_req(REQ_SCHED, 32'hFFFF_FFFF, DLY_W'($urandom()), SP_W'($urandom()));
    send_req(REQ_ADD, 32'hFFFF_FFFF, DLY_W'($urandom()), SP_W'($urandom()));
    send_req(REQ_DELAY, 32'hFFFF_FFFF, -16'sd1, SP_W'($urandom()));
    send_req(REQ_SCHED, 32'h0000_0002, DLY_W'($urandom()), SP_W'($urandom()));

    // ---- random phases: new slot count and idle pattern each time ----
    clock_ms = 32'd200;
    for (int p = 0; p < 8; p++) begin
      write_max_tasks(CFG_PLAN[p]);
      case (p % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 82; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 82; end
        default: begin src_idle_pct = 9;  sink_stall_pct = 9;  end
      endcase
      // every other phase runs across the 32-bit time wrap
      if (p % 2 == 1) clock_ms = 32'hFFFF_FF80;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // favor adds while the table is nearly empty so schedules have work
        add_lim = (sb.tasks_alive() < 2) ? 45 : 20;
        pick = $urandom_range(0, 99);
        if (pick < add_lim)           rq = REQ_ADD;
        else if (pick < add_lim + 10) rq = REQ_END;
        else if (pick < add_lim + 38) rq = REQ_DELAY;
        else                          rq = REQ_SCHED;

        // mostly short delays so they expire within a few requests
        pick = $urandom_range(0, 99);
        if (pick < 6)       dly = '0;
        else if (pick < 14) dly = DLY_W'($urandom_range(32768, 65535));
        else if (pick < 18) dly = DLY_W'($urandom_range(121, 32767));
        else                dly = DLY_W'($urandom_range(1, 120));

        if ($urandom_range(0, 99) < 3) clock_ms = $urandom();
        else                           clock_ms = clock_ms + $urandom_range(0, 25);

        send_req(rq, clock_ms, dly, SP_W'($urandom()));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("round_robin_task_slot_scheduler_unit_test passed");
    else
      $display("round_robin_task_slot_scheduler_unit_test failed");
    $finish;
  end

endmodule
